### hdl/dfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants of the command frame deframer.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int unsigned SET_FIELDS = 3;
  localparam int unsigned KEPT_BYTES = 3;

  localparam logic [7:0] HEADER_RESET = 8'hAA;
  localparam logic [7:0] TAIL_RESET   = 8'h55;
  localparam logic [7:0] LIMIT_RESET  = 8'd59;

  localparam logic [7:0] CMD_QUERY = 8'h01;
  localparam logic [7:0] CMD_SET   = 8'h02;

  typedef enum logic [1:0] {
    REG_HEADER = 2'd0,
    REG_TAIL   = 2'd1,
    REG_LIMIT  = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4,
    PH_TAIL = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_QUERY_OK  = 3'd0,
    ST_SET_OK    = 3'd1,
    ST_SET_SHORT = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_BAD_SUM   = 3'd4,
    ST_BAD_TAIL  = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] tail_value;
    logic [7:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic       light_on;
    logic       water_on;
    logic       buzzer_on;
    logic       auto_mode;
  } result_t;

endpackage
`default_nettype wire

### hdl/command_frame_deframer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_frame_deframer_core
// Byte stream frame parser: header, command, length, payload, checksum, tail.
//
// Input channel (in_valid, in_stall, rx_byte) takes one received byte per
// transaction. Output channel (out_valid, out_stall and the status fields)
// delivers one status transaction per finished or aborted frame; bytes that
// end no frame give none. Configuration writes (cfg_valid, cfg_ready,
// cfg_index, cfg_data) set header byte, tail byte and payload limit;
// cfg_ready is always high.
// Each byte passes an input register and then the parser into the result
// register, so a status is registered after the tail (or length) byte has
// passed the parser. One byte is taken per cycle while the output side
// does not stall. While a result waits under out_stall the byte in the input
// register is held and in_stall rises; in_stall stays low otherwise.
// Synchronous reset returns the parser to header hunting, empties both
// registers, sets the flags off with auto mode on and loads the default
// header 0xAA, tail 0x55 and limit 59.
// ----------------------------------------------------------------------------
module command_frame_deframer_core
  import dfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      status,
  output logic [7:0]      command_code,
  output logic [7:0]      payload_length,
  output logic            light_on,
  output logic            water_on,
  output logic            buzzer_on,
  output logic            auto_mode,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t       cfg;
  logic       byte_valid;
  logic [7:0] byte_reg;
  logic       step;
  logic       out_free;
  logic       res_valid;
  result_t    res;
  result_t    res_reg;

  // input register
  assign step     = byte_valid && out_free;
  assign in_stall = byte_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      byte_valid <= 1'b1;
    end else if (step) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_reg <= rx_byte;
    end
  end

  dfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .byte_in   (byte_reg),
    .res_valid (res_valid),
    .res       (res)
  );

  dfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res_in    (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_reg)
  );

  assign status         = res_reg.status;
  assign command_code   = res_reg.command_code;
  assign payload_length = res_reg.payload_length;
  assign light_on       = res_reg.light_on;
  assign water_on       = res_reg.water_on;
  assign buzzer_on      = res_reg.buzzer_on;
  assign auto_mode      = res_reg.auto_mode;

endmodule
`default_nettype wire

### hdl/dfr_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_cfg_regs
// Configuration registers: header byte, tail byte and payload length limit.
// ----------------------------------------------------------------------------
module dfr_cfg_regs
  import dfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_value  <= HEADER_RESET;
      cfg.tail_value    <= TAIL_RESET;
      cfg.payload_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_HEADER: cfg.header_value  <= cfg_data;
        REG_TAIL:   cfg.tail_value    <= cfg_data;
        REG_LIMIT:  cfg.payload_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/dfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_parser
// Frame state machine with running sum, kept payload flags and control flags.
// Processes one byte per strobe and reports a status at frame end or abort.
// ----------------------------------------------------------------------------
module dfr_parser
  import dfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  output logic            res_valid,
  output result_t         res
);

  phase_t                  phase, phase_next;
  logic [7:0]              running_sum, running_sum_next;
  logic [7:0]              frame_command, frame_command_next;
  logic [7:0]              frame_length, frame_length_next;
  logic [7:0]              payload_count, payload_count_next;
  logic [7:0]              received_checksum, received_checksum_next;
  logic [KEPT_BYTES-1:0]   kept_nz, kept_nz_next;
  logic [2:0]              manual_flags, manual_flags_next;
  logic                    auto_flag, auto_flag_next;
  logic [7:0]              count_inc;
  status_t                 status;

  assign count_inc = payload_count + 8'd1;

  // next state
  always_comb begin
    phase_next = PH_IDLE;
    unique case (phase)
      PH_CMD:  phase_next = PH_LEN;
      PH_LEN: begin
        if (byte_in > cfg.payload_limit) begin
          phase_next = PH_IDLE;
        end else if (byte_in == 8'd0) begin
          phase_next = PH_SUM;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: phase_next = (count_inc >= frame_length) ? PH_SUM : PH_DATA;
      PH_SUM:  phase_next = PH_TAIL;
      PH_TAIL: phase_next = PH_IDLE;
      default: phase_next = (byte_in == cfg.header_value) ? PH_CMD : PH_IDLE;
    endcase
  end

  // data path and result
  always_comb begin
    running_sum_next       = running_sum;
    frame_command_next     = frame_command;
    frame_length_next      = frame_length;
    payload_count_next     = payload_count;
    received_checksum_next = received_checksum;
    kept_nz_next           = kept_nz;
    manual_flags_next      = manual_flags;
    auto_flag_next         = auto_flag;
    res_valid              = 1'b0;
    status                 = ST_QUERY_OK;
    unique case (phase)
      PH_CMD: begin
        frame_command_next = byte_in;
        running_sum_next   = running_sum + byte_in;
      end
      PH_LEN: begin
        frame_length_next  = byte_in;
        payload_count_next = 8'd0;
        running_sum_next   = running_sum + byte_in;
        if (byte_in > cfg.payload_limit) begin
          res_valid = 1'b1;
          status    = ST_TOO_LONG;
        end
      end
      PH_DATA: begin
        if (payload_count < 8'(KEPT_BYTES)) begin
          kept_nz_next[payload_count[1:0]] = (byte_in != 8'd0);
        end
        running_sum_next   = running_sum + byte_in;
        payload_count_next = count_inc;
      end
      PH_SUM: received_checksum_next = byte_in;
      PH_TAIL: begin
        res_valid = 1'b1;
        if (byte_in != cfg.tail_value) begin
          status = ST_BAD_TAIL;
        end else if (running_sum != received_checksum) begin
          status = ST_BAD_SUM;
        end else if (frame_command == CMD_QUERY) begin
          status = ST_QUERY_OK;
        end else if (frame_command != CMD_SET) begin
          status = ST_UNKNOWN;
        end else if (frame_length < 8'(SET_FIELDS)) begin
          status = ST_SET_SHORT;
        end else begin
          status            = ST_SET_OK;
          manual_flags_next = kept_nz;
          auto_flag_next    = 1'b0;
        end
      end
      default: begin
        if (byte_in == cfg.header_value) begin
          running_sum_next       = byte_in;
          frame_command_next     = 8'd0;
          frame_length_next      = 8'd0;
          payload_count_next     = 8'd0;
          received_checksum_next = 8'd0;
          kept_nz_next           = '0;
        end
      end
    endcase
    res.status         = status;
    res.command_code   = frame_command_next;
    res.payload_length = frame_length_next;
    res.light_on       = manual_flags_next[0];
    res.water_on       = manual_flags_next[1];
    res.buzzer_on      = manual_flags_next[2];
    res.auto_mode      = auto_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      running_sum       <= 8'd0;
      frame_command     <= 8'd0;
      frame_length      <= 8'd0;
      payload_count     <= 8'd0;
      received_checksum <= 8'd0;
      manual_flags      <= 3'd0;
      auto_flag         <= 1'b1;
    end else if (step) begin
      phase             <= phase_next;
      running_sum       <= running_sum_next;
      frame_command     <= frame_command_next;
      frame_length      <= frame_length_next;
      payload_count     <= payload_count_next;
      received_checksum <= received_checksum_next;
      manual_flags      <= manual_flags_next;
      auto_flag         <= auto_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      kept_nz <= kept_nz_next;
    end
  end

endmodule
`default_nettype wire

### hdl/dfr_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_out_reg
// Result register of the output channel with valid/stall flow control.
// ----------------------------------------------------------------------------
module dfr_out_reg
  import dfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         free,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      res_out
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

### sim/tb_command_frame_deframer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_frame_deframer_core
// Checks the command frame deframer against a cycle-free frame parser kept in
// the bench. A short stimulus list covers every status code and the field
// extremes, then random frames (mostly well formed, some truncated or
// corrupted, with noise between them) run under several header, tail and
// payload limit settings and under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_command_frame_deframer_core;
  import dfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_LIMIT    = 1000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_ITEMS    = 180;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    result_t    want;
  } directed_row_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t R_QUERY = '{ST_QUERY_OK, CMD_QUERY, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam result_t R_LONG  = '{ST_TOO_LONG, CMD_SET, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam result_t R_SHORT = '{ST_SET_SHORT, CMD_SET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam result_t R_UNKNOWN = '{ST_UNKNOWN, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam result_t R_BAD_SUM = '{ST_BAD_SUM, CMD_QUERY, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam result_t R_BAD_TAIL = '{ST_BAD_TAIL, CMD_QUERY, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};

  localparam int DIRECTED_ROWS = 37;
  localparam directed_row_t DIRECTED_STIM [DIRECTED_ROWS] = '{
    // noise while hunting
    '{8'h00, 1'b0, NO_RESULT},
    // query, zero length
    '{HEADER_RESET, 1'b0, NO_RESULT}, '{CMD_QUERY, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'hAB, 1'b0, NO_RESULT}, '{TAIL_RESET, 1'b1, R_QUERY},
    // length above limit
    '{HEADER_RESET, 1'b0, NO_RESULT}, '{CMD_SET, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, R_LONG},
    // set with no payload
    '{HEADER_RESET, 1'b0, NO_RESULT}, '{CMD_SET, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'hAC, 1'b0, NO_RESULT}, '{TAIL_RESET, 1'b1, R_SHORT},
    // unknown command
    '{HEADER_RESET, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'hA9, 1'b0, NO_RESULT}, '{TAIL_RESET, 1'b1, R_UNKNOWN},
    // checksum wrong
    '{HEADER_RESET, 1'b0, NO_RESULT}, '{CMD_QUERY, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{TAIL_RESET, 1'b1, R_BAD_SUM},
    // tail wrong
    '{HEADER_RESET, 1'b0, NO_RESULT}, '{CMD_QUERY, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'hAB, 1'b0, NO_RESULT}, '{8'hFF, 1'b1, R_BAD_TAIL},
    // set ok, header value inside the payload
    '{HEADER_RESET, 1'b0, NO_RESULT}, '{CMD_SET, 1'b0, NO_RESULT},
    '{8'h03, 1'b0, NO_RESULT}, '{HEADER_RESET, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'h58, 1'b0, NO_RESULT}, '{TAIL_RESET, 1'b0, NO_RESULT}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] status;
  logic [7:0] command_code;
  logic [7:0] payload_length;
  logic       light_on;
  logic       water_on;
  logic       buzzer_on;
  logic       auto_mode;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_HEADER;
  logic [7:0] cfg_data = 8'h00;

  // parser mirror
  phase_t     parse_state = PH_IDLE;
  logic [7:0] frame_sum = 8'h00;
  logic [7:0] frame_cmd = 8'h00;
  logic [7:0] frame_len = 8'h00;
  logic [7:0] data_count = 8'h00;
  logic [7:0] frame_check = 8'h00;
  logic [7:0] data_head [KEPT_BYTES];
  logic [2:0] req_flags = 3'b000;
  logic       auto_ctl = 1'b1;
  cfg_t       shadow_cfg = '{HEADER_RESET, TAIL_RESET, LIMIT_RESET};
  cfg_t       gen_cfg = '{HEADER_RESET, TAIL_RESET, LIMIT_RESET};

  result_t    pending_status [$];
  logic       typed_use = 1'b0;
  result_t    typed_want = '0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         bytes_taken = 0;
  int         statuses_checked = 0;
  int         reg_writes = 0;
  int         fail_count = 0;
  int         idle_cycles = 0;
  int         phases_run = 0;
  int         status_seen [8] = '{default: 0};

  command_frame_deframer_core dut (.*);

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic void deframe_byte(input logic [7:0] b, output logic emitted,
                                       output result_t res);
    status_t verdict;
    int k;
    emitted = 1'b0;
    verdict = ST_QUERY_OK;
    res = '0;
    case (parse_state)
      PH_CMD: begin
        frame_cmd = b;
        frame_sum = frame_sum + b;
        parse_state = PH_LEN;
      end
      PH_LEN: begin
        frame_len = b;
        data_count = 8'h00;
        frame_sum = frame_sum + b;
        if (b > shadow_cfg.payload_limit) begin
          parse_state = PH_IDLE;
          verdict = ST_TOO_LONG;
          emitted = 1'b1;
        end else if (b == 8'h00) begin
          parse_state = PH_SUM;
        end else begin
          parse_state = PH_DATA;
        end
      end
      PH_DATA: begin
        if (data_count < KEPT_BYTES) data_head[data_count] = b;
        frame_sum = frame_sum + b;
        data_count = data_count + 8'd1;
        if (data_count >= frame_len) parse_state = PH_SUM;
      end
      PH_SUM: begin
        frame_check = b;
        parse_state = PH_TAIL;
      end
      PH_TAIL: begin
        emitted = 1'b1;
        parse_state = PH_IDLE;
        if (b != shadow_cfg.tail_value) verdict = ST_BAD_TAIL;
        else if (frame_sum != frame_check) verdict = ST_BAD_SUM;
        else if (frame_cmd == CMD_QUERY) verdict = ST_QUERY_OK;
        else if (frame_cmd != CMD_SET) verdict = ST_UNKNOWN;
        else if (frame_len < SET_FIELDS) verdict = ST_SET_SHORT;
        else begin
          req_flags = {data_head[2] != 8'h00, data_head[1] != 8'h00, data_head[0] != 8'h00};
          auto_ctl = 1'b0;
          verdict = ST_SET_OK;
        end
      end
      default: begin
        parse_state = PH_IDLE;
        if (b == shadow_cfg.header_value) begin
          frame_sum = b;
          frame_cmd = 8'h00;
          frame_len = 8'h00;
          data_count = 8'h00;
          frame_check = 8'h00;
          for (k = 0; k < KEPT_BYTES; k++) data_head[k] = 8'h00;
          parse_state = PH_CMD;
        end
      end
    endcase
    if (emitted) begin
      res = '{verdict, frame_cmd, frame_len, req_flags[0], req_flags[1], req_flags[2],
              auto_ctl};
    end
  endfunction

  always @(posedge clk) begin : monitor
    logic    emitted;
    logic    active;
    result_t predicted;
    result_t want;
    if (!rst) begin
      active = 1'b0;
      if (cfg_valid && cfg_ready) begin
        active = 1'b1;
        reg_writes++;
        case (cfg_index)
          REG_HEADER: shadow_cfg.header_value = cfg_data;
          REG_TAIL:   shadow_cfg.tail_value = cfg_data;
          REG_LIMIT:  shadow_cfg.payload_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        active = 1'b1;
        bytes_taken++;
        deframe_byte(rx_byte, emitted, predicted);
        if (emitted) pending_status.push_back(typed_use ? typed_want : predicted);
      end
      if (out_valid && !out_stall) begin
        active = 1'b1;
        status_seen[status]++;
        if (pending_status.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected status transaction: status %0d cmd %02h len %02h",
                     status, command_code, payload_length);
          end
        end else begin
          want = pending_status.pop_front();
          statuses_checked++;
          if (want.status !== status || want.command_code !== command_code ||
              want.payload_length !== payload_length || want.light_on !== light_on ||
              want.water_on !== water_on || want.buzzer_on !== buzzer_on ||
              want.auto_mode !== auto_mode) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("mismatch: expected status %0d cmd %02h len %02h lwb %b%b%b auto %b",
                       want.status, want.command_code, want.payload_length,
                       want.light_on, want.water_on, want.buzzer_on, want.auto_mode);
              $display("          actual   status %0d cmd %02h len %02h lwb %b%b%b auto %b",
                       status, command_code, payload_length,
                       light_on, water_on, buzzer_on, auto_mode);
            end
          end
        end
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int target;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    target = bytes_taken + 1;
    do @(negedge clk); while (bytes_taken != target);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    int target;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    target = reg_writes + 1;
    do @(negedge clk); while (reg_writes != target);
  endtask

  task automatic set_config(input logic [7:0] hdr, input logic [7:0] tail,
                            input logic [7:0] limit);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_TAIL, tail);
    write_reg(REG_LIMIT, limit);
    cfg_valid <= 1'b0;
    gen_cfg = '{hdr, tail, limit};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_status.size() != 0);
  endtask

  task automatic prepare_config();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(inout int items);
    logic [7:0] frame_bytes [$];
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    int r;
    int n;
    int k;
    // noise between frames
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        b = 8'($urandom);
        if (b == gen_cfg.header_value) b = b ^ 8'h01;
        send_byte(b);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 40) cmd = CMD_SET;
    else if (r < 75) cmd = CMD_QUERY;
    else cmd = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) len = 8'($urandom_range(0, 6));
    else if (r < 85)
      len = 8'($urandom_range(0, gen_cfg.payload_limit < 16 ? gen_cfg.payload_limit : 16));
    else if (r < 95 && gen_cfg.payload_limit != 8'hFF)
      len = 8'($urandom_range(gen_cfg.payload_limit + 1, 255));
    else len = gen_cfg.payload_limit;
    frame_bytes.push_back(gen_cfg.header_value);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(len);
    sum = gen_cfg.header_value + cmd + len;
    if (len <= gen_cfg.payload_limit) begin
      for (k = 0; k < len; k++) begin
        b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        sum = sum + b;
        frame_bytes.push_back(b);
      end
      frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : sum);
      frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : gen_cfg.tail_value);
    end
    n = frame_bytes.size();
    // broken frame
    if ($urandom_range(0, 19) == 0) n = $urandom_range(1, n - 1);
    for (k = 0; k < n; k++) send_byte(frame_bytes[k]);
    items += n;
  endtask

  task automatic run_phase(input int idle, input int stall);
    int items;
    int frames;
    idle_pct = idle;
    stall_pct = stall;
    items = 0;
    frames = 0;
    phases_run++;
    while (items < PHASE_ITEMS) begin
      if (frames % 16 == 15) wait_drained();
      send_frame(items);
      frames++;
    end
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < KEPT_BYTES; i++) data_head[i] = 8'h00;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      typed_use = DIRECTED_STIM[i].typed;
      typed_want = DIRECTED_STIM[i].want;
      send_byte(DIRECTED_STIM[i].data);
    end
    typed_use = 1'b0;

    prepare_config();
    set_config(8'($urandom), 8'($urandom), 8'd8);
    run_phase(0, 0);
    prepare_config();
    write_reg(REG_UNUSED, 8'($urandom));
    set_config(8'h00, 8'hFF, 8'hFF);
    run_phase(76, 0);
    prepare_config();
    set_config(8'hFF, 8'h00, 8'h00);
    run_phase(0, 76);
    prepare_config();
    set_config(8'($urandom), 8'($urandom), 8'($urandom_range(0, 20)));
    run_phase(25, 25);
    prepare_config();
    set_config(HEADER_RESET, TAIL_RESET, LIMIT_RESET);
    run_phase(0, 0);

    idle_pct = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    for (i = 0; i < DRAIN_LIMIT && pending_status.size() != 0; i++) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (pending_status.size() != 0) begin
      fail_count++;
      $display("%0d expected status transactions never arrived", pending_status.size());
    end

    $display("run: %0d bytes, %0d statuses checked, %0d register writes, %0d random phases",
             bytes_taken, statuses_checked, reg_writes, phases_run);
    $display("statuses: query %0d set %0d short %0d unknown %0d sum %0d tail %0d long %0d",
             status_seen[ST_QUERY_OK], status_seen[ST_SET_OK], status_seen[ST_SET_SHORT],
             status_seen[ST_UNKNOWN], status_seen[ST_BAD_SUM], status_seen[ST_BAD_TAIL],
             status_seen[ST_TOO_LONG]);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/dfr_pkg.sv
hdl/dfr_cfg_regs.sv
hdl/dfr_parser.sv
hdl/dfr_out_reg.sv
hdl/command_frame_deframer_core.sv
sim/tb_command_frame_deframer_core.sv
